>>> hw/rtl/rtll_pkg.sv
`default_nettype none

package rtll_pkg;

    // Field widths of one request and one response.
    localparam int unsigned OP_W     = 2;
    localparam int unsigned ADDR_W   = 64;
    localparam int unsigned HOP_W    = 16;
    localparam int unsigned LIMIT_W  = 8;
    localparam int unsigned STATUS_W = 2;

    // Request opcodes; the fourth code is unused and leaves the table alone.
    localparam logic [OP_W-1:0] OP_FORWARD = 2'd0;
    localparam logic [OP_W-1:0] OP_LEARN   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNREACHABLE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_HOP_EXCEEDED = 2'd2;

    // Sequencer states.
    typedef enum logic
    {
        SEQ_IDLE,
        SEQ_RESOLVE
    } rtll_state_t;

    // Control broadcast from the sequencer to every table cell.
    typedef struct packed
    {
        logic              capture;
        logic              write_dest;
        logic              write_hop;
        logic              clear;
        logic [ADDR_W-1:0] cmp_addr;
        logic [ADDR_W-1:0] wr_addr;
        logic [HOP_W-1:0]  wr_hop;
    } rtll_cell_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/rtll_if.sv
`default_nettype none

// Request channel: one route operation per transfer.
interface rtll_req_if;
    import rtll_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    opcode;
    logic [ADDR_W-1:0]  dest_address;
    logic [HOP_W-1:0]   learned_hop;
    logic [LIMIT_W-1:0] hop_limit_in;

    modport source
    (
        output valid, opcode, dest_address, learned_hop, hop_limit_in,
        input  ready
    );

    modport sink
    (
        input  valid, opcode, dest_address, learned_hop, hop_limit_in,
        output ready
    );
endinterface

// Response channel: one result per request.
interface rtll_rsp_if;
    import rtll_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HOP_W-1:0]    fwd_hop;
    logic [LIMIT_W-1:0]  hop_limit_out;
    logic                was_update;

    modport source
    (
        output valid, status, fwd_hop, hop_limit_out, was_update,
        input  ready
    );

    modport sink
    (
        input  valid, status, fwd_hop, hop_limit_out, was_update,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/route_table_lookup_learn.sv
// Channel  Role    Payload                                            Transfer
// -------  ------  -------------------------------------------------  -------------------
// req      sink    opcode, dest_address, learned_hop, hop_limit_in    valid & ready
// rsp      source  status, fwd_hop, hop_limit_out, was_update         valid & ready
//
// On the transfer edge every slot latches its address compare; in the
// resolve state the sequencer then resolves the lowest match, updates the
// table and loads the response register. The next request is taken while a
// response still waits; its resolve cycle stalls until rsp is free.
// rst_n clears the table, the insert pointer and all handshake state.

`default_nettype none

module route_table_lookup_learn
    import rtll_pkg::*;
#(
    parameter int unsigned ENTRIES = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    rtll_req_if.sink   req,
    rtll_rsp_if.source rsp
);

    localparam int unsigned PTR_W = $clog2(ENTRIES);

    rtll_state_t          state_reg;
    rtll_state_t          state_next;
    logic [PTR_W-1:0]     ptr_reg;
    logic [PTR_W-1:0]     ptr_next;
    logic [OP_W-1:0]      op_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [HOP_W-1:0]     lhop_reg;
    logic [LIMIT_W-1:0]   limit_reg;

    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [HOP_W-1:0]     nhop_reg;
    logic [LIMIT_W-1:0]   lim_out_reg;
    logic                 upd_reg;

    logic                 take;
    logic                 fire;
    logic                 hit;
    logic [HOP_W-1:0]     hop_sel;
    logic [ENTRIES:0]     found;
    logic [ENTRIES-1:0]   first_vec;
    logic [ENTRIES-1:0]   wr_sel;
    logic [HOP_W-1:0]     cell_hop [ENTRIES];
    rtll_cell_ctl_t       cell_ctl;

    logic [STATUS_W-1:0]  status_calc;
    logic [HOP_W-1:0]     nhop_calc;
    logic [LIMIT_W-1:0]   lim_calc;
    logic                 upd_calc;

    // Handshake: a request is taken whenever no earlier one is resolving.
    assign req.ready = (state_reg == SEQ_IDLE);
    assign take      = req.valid && req.ready;
    assign fire      = (state_reg == SEQ_RESOLVE) && (!out_valid_reg || rsp.ready);

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (take)
                begin
                    state_next = SEQ_RESOLVE;
                end
            end
            SEQ_RESOLVE:
            begin
                if (fire)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // Request fields kept for the resolve cycle.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg    <= req.opcode;
            addr_reg  <= req.dest_address;
            lhop_reg  <= req.learned_hop;
            limit_reg <= req.hop_limit_in;
        end
    end

    // Broadcast control to the cells.
    always_comb
    begin
        cell_ctl            = '0;
        cell_ctl.capture    = take;
        cell_ctl.cmp_addr   = req.dest_address;
        cell_ctl.wr_addr    = addr_reg;
        cell_ctl.wr_hop     = lhop_reg;
        cell_ctl.write_hop  = fire && (op_reg == OP_LEARN);
        cell_ctl.write_dest = fire && (op_reg == OP_LEARN) && !hit;
        cell_ctl.clear      = fire && (op_reg == OP_CLEAR);
    end

    // Row of slots; the found chain picks the lowest matching slot.
    assign found[0] = 1'b0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        assign wr_sel[i] = hit ? first_vec[i] : (ptr_reg == PTR_W'(i));

        rtll_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (cell_ctl),
            .sel       (wr_sel[i]),
            .found_in  (found[i]),
            .found_out (found[i+1]),
            .first     (first_vec[i]),
            .hop       (cell_hop[i])
        );
    end

    assign hit = found[ENTRIES];

    // Next hop of the winning slot; at most one slot is selected.
    always_comb
    begin
        hop_sel = '0;
        for (int unsigned k = 0; k < ENTRIES; k++)
        begin
            hop_sel = hop_sel | (first_vec[k] ? cell_hop[k] : '0);
        end
    end

    // Response fields for the request being resolved.
    always_comb
    begin
        status_calc = ST_OK;
        nhop_calc   = '0;
        lim_calc    = '0;
        upd_calc    = 1'b0;
        case (op_reg)
            OP_FORWARD:
            begin
                if (!hit)
                begin
                    status_calc = ST_UNREACHABLE;
                end
                else if (limit_reg == '0)
                begin
                    status_calc = ST_HOP_EXCEEDED;
                end
                else
                begin
                    nhop_calc = hop_sel;
                    lim_calc  = limit_reg - LIMIT_W'(1);
                end
            end
            OP_LEARN:
            begin
                upd_calc = hit;
            end
            default:
            begin
                status_calc = ST_OK;
            end
        endcase
    end

    // Insert pointer: advances on a new slot, returns to zero on clear.
    always_comb
    begin
        ptr_next = ptr_reg;
        if (fire && (op_reg == OP_CLEAR))
        begin
            ptr_next = '0;
        end
        else if (fire && (op_reg == OP_LEARN) && !hit)
        begin
            ptr_next = (ptr_reg == PTR_W'(ENTRIES - 1)) ? '0 : ptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
        end
    end

    // Response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg  <= status_calc;
            nhop_reg    <= nhop_calc;
            lim_out_reg <= lim_calc;
            upd_reg     <= upd_calc;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.fwd_hop       = nhop_reg;
    assign rsp.hop_limit_out = lim_out_reg;
    assign rsp.was_update    = upd_reg;

`ifndef NO_ASSERTIONS
    // At most one slot wins the lowest-match search.
    a_one_winner : assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(first_vec))
        else $error("more than one slot selected as lowest match");

    // The insert pointer never leaves the table.
    a_ptr_range : assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PTR_W'(ENTRIES - 1))
        else $error("insert pointer out of range");

    // An accepted request is resolved in the following cycle or later.
    a_take_resolve : assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (state_reg == SEQ_RESOLVE))
        else $error("accepted request not held for resolve");

    // A resolved clear leaves the insert pointer at zero.
    a_clear_ptr : assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (op_reg == OP_CLEAR)) |=> (ptr_reg == '0))
        else $error("insert pointer not reset by clear");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/rtll_cell.sv
`default_nettype none

// One table slot: holds an address and its next hop, compares the address
// against the broadcast key, and extends the "match seen lower" chain.
module rtll_cell
    import rtll_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rtll_cell_ctl_t   ctl,
    input  wire logic             sel,
    input  wire logic             found_in,
    output logic                  found_out,
    output logic                  first,
    output logic [HOP_W-1:0]      hop
);

    logic [ADDR_W-1:0] dest_reg;
    logic [HOP_W-1:0]  hop_reg;
    logic              match_reg;

    // Slot contents and the registered compare result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_reg  <= '0;
            hop_reg   <= '0;
            match_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            dest_reg  <= '0;
            hop_reg   <= '0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (ctl.capture)
            begin
                match_reg <= (dest_reg == ctl.cmp_addr);
            end
            if (sel && ctl.write_dest)
            begin
                dest_reg <= ctl.wr_addr;
            end
            if (sel && ctl.write_hop)
            begin
                hop_reg <= ctl.wr_hop;
            end
        end
    end

    // This slot is the winner when it matches and no lower slot did.
    assign first     = match_reg & ~found_in;
    assign found_out = found_in | match_reg;
    assign hop       = hop_reg;

endmodule

`default_nettype wire
